### hw/rtl/depth_to_color_pixel_projection_assert.svh
// Assertion macros for the depth to color pixel projection block
`ifndef DEPTH_TO_COLOR_PIXEL_PROJECTION_ASSERT_SVH
`define DEPTH_TO_COLOR_PIXEL_PROJECTION_ASSERT_SVH

// same-cycle implication
`define DTC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dtc_pkg.sv
// Shared constants and types of the depth to color pixel projection block
`timescale 1ns / 1ps
package dtc_pkg;
   localparam int CoordBits = 12;
   localparam int DepthW    = 16;
   localparam int OffsetW   = 26;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 64;
   localparam int PxW       = 41;
   localparam int CamW      = 46;

   localparam logic [CsrIdxW-1:0] CsrDepthIntr = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrColorIntr = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrRotRow0   = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrRotRow1   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrRotRow2   = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrShift     = 3'd5;
   localparam logic [CsrIdxW-1:0] CsrColorSize = 3'd6;

   typedef struct packed {
      logic [63:0] depth_intr;
      logic [63:0] color_intr;
      logic [47:0] rot0;
      logic [47:0] rot1;
      logic [47:0] rot2;
      logic [47:0] shift;
      logic [23:0] color_size;
   } cfg_type;

   typedef struct packed {
      logic signed [PxW-1:0] px;
      logic signed [PxW-1:0] py;
      logic [DepthW-1:0]     d;
   } point_type;

   typedef struct packed {
      logic signed [CamW-1:0] bx;
      logic signed [CamW-1:0] by;
      logic signed [CamW-1:0] bz;
   } cam_type;

   typedef struct packed {
      logic [CoordBits-1:0] color_col;
      logic [CoordBits-1:0] color_row;
      logic [OffsetW-1:0]   color_offset;
      logic                 hit;
   } rsp_type;
endpackage

### hw/rtl/dtc_if.sv
// Valid/ready channel interfaces for depth samples and color results
`timescale 1ns / 1ps
interface dtc_req_if;
   logic                            valid;
   logic                            ready;
   logic [dtc_pkg::CoordBits-1:0]   depth_col;
   logic [dtc_pkg::CoordBits-1:0]   depth_row;
   logic [dtc_pkg::DepthW-1:0]      depth_value;
   modport source (output valid, depth_col, depth_row, depth_value, input ready);
   modport sink (input valid, depth_col, depth_row, depth_value, output ready);
endinterface

interface dtc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dtc_pkg::CoordBits-1:0]   color_col;
   logic [dtc_pkg::CoordBits-1:0]   color_row;
   logic [dtc_pkg::OffsetW-1:0]     color_offset;
   logic                            hit;
   modport source (output valid, color_col, color_row, color_offset, hit, input ready);
   modport sink (input valid, color_col, color_row, color_offset, hit, output ready);
endinterface

### hw/rtl/dtc_backproj.sv
// Back-projection through depth intrinsics with a pipelined restoring divider
`timescale 1ns / 1ps
module dtc_backproj (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [dtc_pkg::CoordBits-1:0] col,
   input  logic [dtc_pkg::CoordBits-1:0] row,
   input  logic [dtc_pkg::DepthW-1:0]    d,
   input  dtc_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output dtc_pkg::point_type            out
);
   localparam int DivSteps = 40;

   function automatic logic [55:0] div_step(logic [15:0] rem, logic [39:0] num,
                                            logic [15:0] den);
      logic [16:0] t;
      logic [16:0] diff;
      t    = {rem, num[39]};
      diff = t - {1'b0, den};
      if (t >= {1'b0, den}) return {diff[15:0], num[38:0], 1'b1};
      return {t[15:0], num[38:0], 1'b0};
   endfunction

   logic [15:0] cxd, cyd, fxd, fyd;
   assign cxd = cfg.depth_intr[15:0];
   assign cyd = cfg.depth_intr[31:16];
   assign fxd = cfg.depth_intr[47:32];
   assign fyd = cfg.depth_intr[63:48];

   // stage A: centered coordinate
   logic               va_ff;
   logic signed [17:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [15:0]        da_ff;

   assign ex_in = $signed({2'b0, col, 4'b0}) - $signed({2'b0, cxd});
   assign ey_in = $signed({2'b0, row, 4'b0}) - $signed({2'b0, cyd});

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
         da_ff <= d;
      end
   end

   // stage B: product magnitude, loads divider level 0
   logic signed [34:0] prx, pry, negx, negy;
   assign prx  = ex_ff * $signed({1'b0, da_ff});
   assign pry  = ey_ff * $signed({1'b0, da_ff});
   assign negx = -prx;
   assign negy = -pry;

   logic        v_ff  [0:DivSteps];
   logic [39:0] nx_ff [0:DivSteps];
   logic [39:0] ny_ff [0:DivSteps];
   logic [15:0] rx_ff [0:DivSteps];
   logic [15:0] ry_ff [0:DivSteps];
   logic [15:0] dv_ff [0:DivSteps];
   logic        sx_ff [0:DivSteps];
   logic        sy_ff [0:DivSteps];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff[0] <= {(prx[34] ? negx[31:0] : prx[31:0]), 8'b0};
         ny_ff[0] <= {(pry[34] ? negy[31:0] : pry[31:0]), 8'b0};
         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         dv_ff[0] <= da_ff;
         sx_ff[0] <= prx[34];
         sy_ff[0] <= pry[34];
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [55:0] stx, sty;
      assign stx = div_step(rx_ff[k], nx_ff[k], fxd);
      assign sty = div_step(ry_ff[k], ny_ff[k], fyd);

      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else if (en) v_ff[k+1] <= v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k+1] <= stx[55:40];
            nx_ff[k+1] <= stx[39:0];
            ry_ff[k+1] <= sty[55:40];
            ny_ff[k+1] <= sty[39:0];
            dv_ff[k+1] <= dv_ff[k];
            sx_ff[k+1] <= sx_ff[k];
            sy_ff[k+1] <= sy_ff[k];
         end
      end
   end

   // output stage: restore sign
   logic               vo_ff;
   dtc_pkg::point_type out_ff, out_in;
   logic signed [dtc_pkg::PxW-1:0] qx, qy;

   assign qx = $signed({1'b0, nx_ff[DivSteps]});
   assign qy = $signed({1'b0, ny_ff[DivSteps]});

   always_comb begin
      out_in.px = sx_ff[DivSteps] ? -qx : qx;
      out_in.py = sy_ff[DivSteps] ? -qy : qy;
      out_in.d  = dv_ff[DivSteps];
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (en) vo_ff <= v_ff[DivSteps];
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign out_valid = vo_ff;
   assign out       = out_ff;
endmodule

### hw/rtl/dtc_rotate.sv
// Rotation and translation of the back-projected point, three stages
`timescale 1ns / 1ps
module dtc_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dtc_pkg::point_type in,
   input  dtc_pkg::cfg_type   cfg,
   output logic               out_valid,
   output dtc_pkg::cam_type   out
);
   logic [47:0]                    rows [0:2];
   logic signed [dtc_pkg::PxW-1:0] pt   [0:2];

   assign rows[0] = cfg.rot0;
   assign rows[1] = cfg.rot1;
   assign rows[2] = cfg.rot2;
   assign pt[0]   = in.px;
   assign pt[1]   = in.py;
   assign pt[2]   = $signed({17'b0, in.d, 8'b0});

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [56:0] prod_ff [0:2][0:2];
   logic signed [58:0] acc_ff  [0:2];
   logic signed [dtc_pkg::CamW-1:0] b_ff [0:2];
   logic signed [dtc_pkg::CamW-1:0] b_in [0:2];
   logic signed [58:0] rnd [0:2];
   logic signed [58:0] sh  [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= $signed(rows[i][16*j +: 16]) * pt[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= prod_ff[i][0] + prod_ff[i][1] + prod_ff[i][2];
         end
      end
   end

   // divide by 2^14 truncating toward zero, then add translation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i]  = acc_ff[i] + (acc_ff[i][58] ? 59'sd16383 : 59'sd0);
         sh[i]   = rnd[i] >>> 14;
         b_in[i] = $signed(sh[i][dtc_pkg::CamW-1:0])
                   + $signed({cfg.shift[16*i +: 16], 8'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) b_ff[i] <= b_in[i];
      end
   end

   assign out_valid = v3_ff;
   assign out.bx    = b_ff[0];
   assign out.by    = b_ff[1];
   assign out.bz    = b_ff[2];
endmodule

### hw/rtl/dtc_project.sv
// Projection through color intrinsics, bounds check and byte offset
`timescale 1ns / 1ps
module dtc_project (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  dtc_pkg::cam_type in,
   input  dtc_pkg::cfg_type cfg,
   output logic             out_valid,
   output dtc_pkg::rsp_type out
);
   localparam int QSteps = 18;

   function automatic logic [63:0] div_step(logic [45:0] rem, logic [17:0] num,
                                            logic [45:0] den);
      logic [46:0] t;
      logic [46:0] diff;
      t    = {rem, num[17]};
      diff = t - {1'b0, den};
      if (t >= {1'b0, den}) return {diff[45:0], num[16:0], 1'b1};
      return {t[45:0], num[16:0], 1'b0};
   endfunction

   logic [15:0] cxc, cyc, fxc, fyc;
   logic [dtc_pkg::CoordBits-1:0] width, height;
   logic focal_ok;

   assign cxc      = cfg.color_intr[15:0];
   assign cyc      = cfg.color_intr[31:16];
   assign fxc      = cfg.color_intr[47:32];
   assign fyc      = cfg.color_intr[63:48];
   assign width    = cfg.color_size[dtc_pkg::CoordBits-1:0];
   assign height   = cfg.color_size[2*dtc_pkg::CoordBits-1:dtc_pkg::CoordBits];
   assign focal_ok = (cfg.depth_intr[47:32] != '0) && (cfg.depth_intr[63:48] != '0)
                     && (fxc != '0) && (fyc != '0);

   // P1: numerators
   logic               v1_ff, bzpos1_ff;
   logic signed [62:0] nu_ff, nv_ff;
   logic signed [45:0] bz1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nu_ff     <= in.bx * $signed({1'b0, fxc});
         nv_ff     <= in.by * $signed({1'b0, fyc});
         bz1_ff    <= in.bz;
         bzpos1_ff <= (in.bz > 46'sd0);
      end
   end

   // P2: magnitudes and overflow check, loads divider level 0
   logic signed [62:0] negu, negv;
   logic [61:0] mu, mv, lim;
   assign negu = -nu_ff;
   assign negv = -nv_ff;
   assign mu   = nu_ff[62] ? negu[61:0] : nu_ff[61:0];
   assign mv   = nv_ff[62] ? negv[61:0] : nv_ff[61:0];
   assign lim  = {bz1_ff[44:0], 17'b0};

   logic        v_ff    [0:QSteps];
   logic [45:0] ru_ff   [0:QSteps];
   logic [45:0] rv_ff   [0:QSteps];
   logic [17:0] qu_ff   [0:QSteps];
   logic [17:0] qv_ff   [0:QSteps];
   logic [45:0] dz_ff   [0:QSteps];
   logic        su_ff   [0:QSteps];
   logic        sv_ff   [0:QSteps];
   logic        ok_ff   [0:QSteps];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ru_ff[0] <= {2'b0, mu[61:18]};
         rv_ff[0] <= {2'b0, mv[61:18]};
         qu_ff[0] <= mu[17:0];
         qv_ff[0] <= mv[17:0];
         dz_ff[0] <= bz1_ff;
         su_ff[0] <= nu_ff[62];
         sv_ff[0] <= nv_ff[62];
         ok_ff[0] <= bzpos1_ff && (mu < lim) && (mv < lim);
      end
   end

   for (genvar k = 0; k < QSteps; k++) begin : g_div
      logic [63:0] stu, stv;
      assign stu = div_step(ru_ff[k], qu_ff[k], dz_ff[k]);
      assign stv = div_step(rv_ff[k], qv_ff[k], dz_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else if (en) v_ff[k+1] <= v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ru_ff[k+1] <= stu[63:18];
            qu_ff[k+1] <= stu[17:0];
            rv_ff[k+1] <= stv[63:18];
            qv_ff[k+1] <= stv[17:0];
            dz_ff[k+1] <= dz_ff[k];
            su_ff[k+1] <= su_ff[k];
            sv_ff[k+1] <= sv_ff[k];
            ok_ff[k+1] <= ok_ff[k];
         end
      end
   end

   // F1: signed quotient plus principal point
   logic               vf1_ff, okf1_ff;
   logic signed [19:0] u_ff, vq_ff;
   logic signed [18:0] squ, sqv, pqu, pqv;

   assign pqu = $signed({1'b0, qu_ff[QSteps]});
   assign pqv = $signed({1'b0, qv_ff[QSteps]});
   assign squ = su_ff[QSteps] ? -pqu : pqu;
   assign sqv = sv_ff[QSteps] ? -pqv : pqv;

   always_ff @(posedge clock) begin
      if (reset) vf1_ff <= 1'b0;
      else if (en) vf1_ff <= v_ff[QSteps];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= $signed({squ[18], squ}) + $signed({4'b0, cxc});
         vq_ff   <= $signed({sqv[18], sqv}) + $signed({4'b0, cyc});
         okf1_ff <= ok_ff[QSteps];
      end
   end

   // F2: bounds and row product
   logic        vf2_ff, hit_ff, hit_in;
   logic [dtc_pkg::CoordBits-1:0] ccol_ff, crow_ff;
   logic [2*dtc_pkg::CoordBits-1:0] prod_ff;

   assign hit_in = okf1_ff && focal_ok && !u_ff[19] && !vq_ff[19]
                   && (u_ff[18:4] < {3'b0, width}) && (vq_ff[18:4] < {3'b0, height});

   always_ff @(posedge clock) begin
      if (reset) vf2_ff <= 1'b0;
      else if (en) vf2_ff <= vf1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         ccol_ff <= u_ff[dtc_pkg::CoordBits+3:4];
         crow_ff <= vq_ff[dtc_pkg::CoordBits+3:4];
         prod_ff <= vq_ff[dtc_pkg::CoordBits+3:4] * width;
      end
   end

   // F3: result register
   logic             vf3_ff;
   dtc_pkg::rsp_type out_ff, out_in;
   logic [2*dtc_pkg::CoordBits:0] lin;
   logic [dtc_pkg::OffsetW+1:0]   off3;

   assign lin  = {1'b0, prod_ff} + {{(dtc_pkg::CoordBits+1){1'b0}}, ccol_ff};
   assign off3 = {1'b0, lin, 1'b0} + {2'b0, lin};

   always_comb begin
      out_in.hit          = hit_ff;
      out_in.color_col    = hit_ff ? ccol_ff : '0;
      out_in.color_row    = hit_ff ? crow_ff : '0;
      out_in.color_offset = hit_ff ? off3[dtc_pkg::OffsetW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) vf3_ff <= 1'b0;
      else if (en) vf3_ff <= vf2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign out_valid = vf3_ff;
   assign out       = out_ff;
endmodule

### hw/rtl/depth_to_color_pixel_projection.sv
// Throughput: one depth sample per cycle while the result is not held;
// the 40-step and 18-step divider pipelines and all other stages take a
// new item every cycle while not stalled. A held result stalls every
// stage at once; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// registers with their defaults: identity rotation, everything else zero.
`timescale 1ns / 1ps
`include "depth_to_color_pixel_projection_assert.svh"
module depth_to_color_pixel_projection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dtc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dtc_pkg::CsrDataW-1:0]  csr_wdata,
   dtc_req_if.sink                       req_port,
   dtc_rsp_if.source                     rsp_port
);
   dtc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_intr <= '0;
         cfg_ff.color_intr <= '0;
         cfg_ff.rot0       <= 48'h0000_0000_4000;
         cfg_ff.rot1       <= 48'h0000_4000_0000;
         cfg_ff.rot2       <= 48'h4000_0000_0000;
         cfg_ff.shift      <= '0;
         cfg_ff.color_size <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dtc_pkg::CsrDepthIntr: cfg_ff.depth_intr <= csr_wdata;
            dtc_pkg::CsrColorIntr: cfg_ff.color_intr <= csr_wdata;
            dtc_pkg::CsrRotRow0:   cfg_ff.rot0       <= csr_wdata[47:0];
            dtc_pkg::CsrRotRow1:   cfg_ff.rot1       <= csr_wdata[47:0];
            dtc_pkg::CsrRotRow2:   cfg_ff.rot2       <= csr_wdata[47:0];
            dtc_pkg::CsrShift:     cfg_ff.shift      <= csr_wdata[47:0];
            dtc_pkg::CsrColorSize: cfg_ff.color_size <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   logic               en;
   logic               bp_valid, rot_valid, out_valid;
   dtc_pkg::point_type bp_out;
   dtc_pkg::cam_type   rot_out;
   dtc_pkg::rsp_type   rsp;

   // global advance: the result register is free or being drained
   assign en = !out_valid || rsp_port.ready;
   assign req_port.ready = en;

   dtc_backproj u_backproj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_port.valid),
      .col       (req_port.depth_col),
      .row       (req_port.depth_row),
      .d         (req_port.depth_value),
      .cfg       (cfg_ff),
      .out_valid (bp_valid),
      .out       (bp_out)
   );

   dtc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (bp_valid),
      .in        (bp_out),
      .cfg       (cfg_ff),
      .out_valid (rot_valid),
      .out       (rot_out)
   );

   dtc_project u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rot_valid),
      .in        (rot_out),
      .cfg       (cfg_ff),
      .out_valid (out_valid),
      .out       (rsp)
   );

   assign rsp_port.valid        = out_valid;
   assign rsp_port.color_col    = rsp.color_col;
   assign rsp_port.color_row    = rsp.color_row;
   assign rsp_port.color_offset = rsp.color_offset;
   assign rsp_port.hit          = rsp.hit;

   `DTC_ASSERT_IMP(a_miss_zero, clock, reset, rsp_port.valid && !rsp_port.hit, rsp_port.color_col == '0 && rsp_port.color_row == '0 && rsp_port.color_offset == '0, "miss carries nonzero fields")
   `DTC_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_port.valid && !rsp_port.ready, !req_port.ready, "input taken while result held")
   `DTC_ASSERT_IMP(a_hit_in_image, clock, reset, rsp_port.valid && rsp_port.hit, rsp_port.color_col < cfg_ff.color_size[11:0] && rsp_port.color_row < cfg_ff.color_size[23:12], "hit outside color image")
   `DTC_ASSERT_NXT(a_held_result_stable, clock, reset, rsp_port.valid && !rsp_port.ready, $stable(rsp), "held result changed")
endmodule
